// ===== hdl/sptf_pkg.sv =====
// Shared types and constants for the sprite pixel texel fetch block.
package sptf_pkg;

    // Object table and affine group sizes, bitmap-mode tile floor
    localparam int NUM_OBJECTS       = 128;
    localparam int NUM_AFFINE_GROUPS = 32;
    localparam int BITMAP_MIN_TILE   = 512;

    localparam int OBJ_AW   = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int COEF_NUM = NUM_AFFINE_GROUPS * 4;

    // Item kinds
    localparam logic [2:0] CMD_TILE = 3'd0;
    localparam logic [2:0] CMD_PAL  = 3'd1;
    localparam logic [2:0] CMD_AFF  = 3'd2;
    localparam logic [2:0] CMD_GEO  = 3'd3;
    localparam logic [2:0] CMD_ATTR = 3'd4;
    localparam logic [2:0] CMD_DRAW = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_LINEAR = 2'd1;
    localparam logic [1:0] CFG_MOS_W  = 2'd2;
    localparam logic [1:0] CFG_MOS_H  = 2'd3;

    // Affine sequence: four coefficient reads, then products, then sums
    localparam logic [3:0] AFF_LAST = 4'd5;
    // Mosaic remainder: one bit of the 9-bit coordinate per step
    localparam logic [3:0] MOS_LAST = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OBJ,
        ST_AFF,
        ST_COORD,
        ST_MOS,
        ST_ADDR,
        ST_TEXEL,
        ST_PAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic aff_clr;
        logic aff_step;
        logic coord;
        logic mos_step;
        logic mos_apply;
        logic addr;
        logic texel;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic draw_ok;
        logic affine;
        logic mosaic;
        logic aff_done;
        logic mos_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/sptf_ctrl.sv =====
// Sequencer that steps one item through the fetch datapath.
module sptf_ctrl
    import sptf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through the item
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC:  state_next = status.draw_ok ? ST_OBJ : ST_DONE;
            ST_OBJ:   state_next = status.affine ? ST_AFF : ST_COORD;
            ST_AFF:   if (status.aff_done) state_next = ST_COORD;
            ST_COORD: state_next = status.mosaic ? ST_MOS : ST_ADDR;
            ST_MOS:   if (status.mos_done) state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_TEXEL;
            ST_TEXEL: state_next = ST_PAL;
            ST_PAL:   state_next = ST_DONE;
            ST_DONE:  if (status.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            ST_EXEC:  cmd.exec = 1'b1;
            ST_OBJ:   cmd.aff_clr = 1'b1;
            ST_AFF:   cmd.aff_step = 1'b1;
            ST_COORD: cmd.coord = 1'b1;
            ST_MOS:
            begin
                cmd.mos_step  = !status.mos_done;
                cmd.mos_apply = status.mos_done;
            end
            ST_ADDR:  cmd.addr = 1'b1;
            ST_TEXEL: cmd.texel = 1'b1;
            ST_PAL:   ;
            ST_DONE:  cmd.load_out = status.out_free;
            default:  ;
        endcase
    end

endmodule

// ===== hdl/sptf_dp.sv =====
// Datapath: stores, coordinate mapping, mosaic, tile address and texel lookup.
module sptf_dp
    import sptf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic [2:0]  in_kind,
    input  logic [14:0] in_index,
    input  logic [53:0] in_data,
    input  logic [7:0]  in_px,
    input  logic [7:0]  in_py,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic        out_visible,
    output logic [15:0] out_color,
    output logic [1:0]  out_prio
);

    // Stores
    logic [7:0]  tile_mem [32768];
    logic [15:0] pal_mem  [256];
    logic [15:0] coef_mem [COEF_NUM];
    logic [53:0] geo_mem  [NUM_OBJECTS];
    logic [25:0] attr_mem [NUM_OBJECTS];

    logic [7:0]  tile_q;
    logic [15:0] pal_q;
    logic [15:0] coef_q;
    logic [53:0] geo_q;
    logic [25:0] attr_q;

    // Configuration
    logic [2:0] mode_reg;
    logic       linear_reg;
    logic [3:0] mos_w_reg;
    logic [3:0] mos_h_reg;

    // Item and working registers
    logic [2:0]  kind_reg;
    logic [14:0] idx_reg;
    logic [53:0] data_reg;
    logic [7:0]  px_reg, py_reg;
    logic        hide_reg;
    logic [3:0]  cnt_reg;
    logic signed [26:0] prod_reg;
    logic signed [27:0] rx_reg, ry_reg;
    logic [8:0]  lx_reg, ly_reg;
    logic [8:0]  shx_reg, shy_reg;
    logic [3:0]  remx_reg, remy_reg;
    logic        nib_reg;
    logic        mvalid_reg;
    logic        vis_reg;
    logic [15:0] color_reg;
    logic [1:0]  prio_reg;

    // Object record fields
    logic signed [10:0] ox, oy, cx, cy, dx, dy, lxn, lyn, mul_op;
    logic [8:0] xs, ys;
    logic       affine, hflip, vflip, bpp8, mosaic, disabled;
    logic [4:0] group;
    logic [9:0] name;
    logic [3:0] bank;

    assign ox = 11'($signed(geo_q[8:0]));
    assign oy = 11'($signed(geo_q[17:9]));
    assign cx = 11'($signed(geo_q[26:18]));
    assign cy = 11'($signed(geo_q[35:27]));
    assign xs = geo_q[44:36];
    assign ys = geo_q[53:45];
    assign affine   = attr_q[0];
    assign disabled = attr_q[1];
    assign group    = attr_q[6:2];
    assign hflip    = attr_q[5];
    assign vflip    = attr_q[6];
    assign mosaic   = attr_q[7];
    assign name     = attr_q[17:8];
    assign bpp8     = attr_q[18];
    assign bank     = attr_q[22:19];

    assign dx  = $signed({3'b000, px_reg}) - cx;
    assign dy  = $signed({3'b000, py_reg}) - cy;
    assign lxn = $signed({3'b000, px_reg}) - ox;
    assign lyn = $signed({3'b000, py_reg}) - oy;

    logic draw_ok;
    assign draw_ok = (kind_reg == CMD_DRAW) && (32'(idx_reg) < NUM_OBJECTS);

    // Load configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            linear_reg <= 1'b0;
            mos_w_reg  <= '0;
            mos_h_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[2:0];
                CFG_LINEAR: linear_reg <= cfg_data[0];
                CFG_MOS_W:  mos_w_reg  <= cfg_data;
                CFG_MOS_H:  mos_h_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= in_kind;
            idx_reg  <= in_index;
            data_reg <= in_data;
            px_reg   <= in_px;
            py_reg   <= in_py;
        end
    end

    // Write stores and read the object record
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            case (kind_reg)
                CMD_TILE: tile_mem[idx_reg] <= data_reg[7:0];
                CMD_PAL:  pal_mem[idx_reg[7:0]] <= data_reg[15:0];
                CMD_AFF:
                    if (32'(idx_reg) < COEF_NUM)
                        coef_mem[idx_reg[6:0]] <= data_reg[15:0];
                CMD_GEO:
                    if (32'(idx_reg) < NUM_OBJECTS)
                        geo_mem[idx_reg[OBJ_AW-1:0]] <= data_reg;
                CMD_ATTR:
                    if (32'(idx_reg) < NUM_OBJECTS)
                        attr_mem[idx_reg[OBJ_AW-1:0]] <= data_reg[25:0];
                default: ;
            endcase
            geo_q  <= geo_mem[idx_reg[OBJ_AW-1:0]];
            attr_q <= attr_mem[idx_reg[OBJ_AW-1:0]];
        end
    end

    // Affine: fetch coefficients, multiply, accumulate
    logic [6:0] coef_base;
    logic [4:0] grp_wrap;
    assign grp_wrap  = 5'(32'(group) % NUM_AFFINE_GROUPS);
    assign coef_base = {grp_wrap, 2'b00};
    assign mul_op    = cnt_reg[0] ? dx : dy;

    always_ff @(posedge clk)
    begin
        if (cmd.aff_step)
        begin
            if (cnt_reg < 4'd4)
                coef_q <= coef_mem[coef_base + {5'b0, cnt_reg[1:0]}];
            if (cnt_reg >= 4'd1 && cnt_reg <= 4'd4)
                prod_reg <= $signed(coef_q) * mul_op;
            case (cnt_reg)
                4'd2:    rx_reg <= 28'(prod_reg);
                4'd3:    rx_reg <= rx_reg + 28'(prod_reg);
                4'd4:    ry_reg <= 28'(prod_reg);
                4'd5:    ry_reg <= ry_reg + 28'(prod_reg);
                default: ;
            endcase
        end
    end

    // Texture coordinates and bounds
    logic signed [27:0] lx_c, ly_c;
    logic in_bounds;
    always_comb
    begin
        if (affine)
        begin
            lx_c = $signed({20'b0, xs[8:1]}) + (rx_reg >>> 8);
            ly_c = $signed({20'b0, ys[8:1]}) + (ry_reg >>> 8);
        end
        else
        begin
            lx_c = 28'(lxn);
            ly_c = 28'(lyn);
        end
        in_bounds = !lx_c[27] && (lx_c < $signed({19'b0, xs}))
                 && !ly_c[27] && (ly_c < $signed({19'b0, ys}));
    end

    // Mosaic remainder, one bit a step
    logic [4:0] divx, divy, tx5, ty5;
    logic [3:0] remx_n, remy_n;
    assign divx = {1'b0, mos_w_reg} + 5'd1;
    assign divy = {1'b0, mos_h_reg} + 5'd1;
    assign tx5  = {remx_reg, shx_reg[8]};
    assign ty5  = {remy_reg, shy_reg[8]};
    assign remx_n = (tx5 >= divx) ? 4'(tx5 - divx) : tx5[3:0];
    assign remy_n = (ty5 >= divy) ? 4'(ty5 - divy) : ty5[3:0];

    // Tile address
    logic [8:0] fx, fy;
    logic [9:0] tile;
    logic [11:0] rowmul;
    logic [9:0] step;
    logic [14:0] taddr;
    always_comb
    begin
        fx = (!affine && hflip) ? 9'(xs - lx_reg - 9'd1) : lx_reg;
        fy = (!affine && vflip) ? 9'(ys - ly_reg - 9'd1) : ly_reg;
        rowmul = fy[8:3] * xs[8:3];
        if (linear_reg)
        begin
            step = 10'(rowmul) + {4'b0, fx[8:3]};
            tile = name + (bpp8 ? {step[8:0], 1'b0} : step);
        end
        else
        begin
            step = bpp8 ? {3'b0, fx[8:3], 1'b0} : {4'b0, fx[8:3]};
            tile = name + {fy[7:3], 5'b0} + step;
        end
        if (bpp8)
            taddr = {tile, 5'b0} + {9'b0, fy[2:0], fx[2:0]};
        else
            taddr = {tile, fy[2:0], fx[2:1]};
    end

    // Texel index
    logic [7:0] ci;
    assign ci = bpp8 ? tile_q : {4'b0, (nib_reg ? tile_q[7:4] : tile_q[3:0])};

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.aff_clr || cmd.coord)
            cnt_reg <= '0;
        else if (cmd.aff_step || cmd.mos_step)
            cnt_reg <= cnt_reg + 4'd1;
    end

    // Coordinate, mosaic, fetch and hide flag
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            hide_reg <= 1'b0;
        if (cmd.exec && !draw_ok)
            hide_reg <= 1'b1;
        if (cmd.coord)
        begin
            lx_reg   <= lx_c[8:0];
            ly_reg   <= ly_c[8:0];
            shx_reg  <= lx_c[8:0];
            shy_reg  <= ly_c[8:0];
            remx_reg <= '0;
            remy_reg <= '0;
            if (!in_bounds || (!affine && disabled))
                hide_reg <= 1'b1;
        end
        if (cmd.mos_step)
        begin
            remx_reg <= remx_n;
            remy_reg <= remy_n;
            shx_reg  <= {shx_reg[7:0], 1'b0};
            shy_reg  <= {shy_reg[7:0], 1'b0};
        end
        if (cmd.mos_apply)
        begin
            lx_reg <= lx_reg - {5'b0, remx_reg};
            ly_reg <= ly_reg - {5'b0, remy_reg};
        end
        if (cmd.addr)
        begin
            tile_q  <= tile_mem[taddr];
            nib_reg <= fx[0];
            if (mode_reg >= 3'd3 && 32'(name) < BITMAP_MIN_TILE)
                hide_reg <= 1'b1;
        end
        if (cmd.texel)
        begin
            pal_q <= pal_mem[bpp8 ? ci : {bank, ci[3:0]}];
            if (ci == 8'd0)
                hide_reg <= 1'b1;
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mvalid_reg <= 1'b0;
        else if (cmd.load_out)
            mvalid_reg <= 1'b1;
        else if (m_tready)
            mvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            vis_reg   <= !hide_reg;
            color_reg <= hide_reg ? 16'd0 : pal_q;
            prio_reg  <= hide_reg ? 2'd0 : attr_q[24:23];
        end
    end

    assign m_tvalid    = mvalid_reg;
    assign out_visible = vis_reg;
    assign out_color   = color_reg;
    assign out_prio    = prio_reg;

    assign status.draw_ok  = draw_ok;
    assign status.affine   = affine;
    assign status.mosaic   = mosaic;
    assign status.aff_done = (cnt_reg == AFF_LAST);
    assign status.mos_done = (cnt_reg == MOS_LAST);
    assign status.out_free = !mvalid_reg || m_tready;

endmodule

// ===== hdl/sprite_pixel_texel_fetch_core.sv =====
// Top level of the sprite pixel texel fetch block.
//
// channel  dir  fields (low bit up)
// s_*      in   tuser: cmd[2:0]; tdata: index[14:0] data[68:15] pixel_x[76:69] pixel_y[84:77]
// m_*      out  tuser: visible; tdata: color[15:0] priority_res[17:16]
// cfg_*    in   index 0 mode, 1 linear layout, 2 mosaic width-1, 3 mosaic height-1
//
// One word at a time. A store write steps through the accept, exec and done states; a draw
// adds object read, coordinate, address, texel and palette states, plus the affine coefficient
// reads through the single multiplier and the bit-serial mosaic remainder where those are set.
// Chained single-port store reads set the pace. Reset clears the sequencer and config; stores
// are undefined. A stalled output word holds while the next word is accepted.
module sprite_pixel_texel_fetch_core
    import sptf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // index, data, pixel_x, pixel_y, zero fill
    input  logic [2:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // color, priority_res, zero fill
    output logic        m_tuser,   // visible
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic [15:0] color;
    logic [1:0]  prio;

    sptf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sptf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_kind     (s_tuser),
        .in_index    (s_tdata[14:0]),
        .in_data     (s_tdata[68:15]),
        .in_px       (s_tdata[76:69]),
        .in_py       (s_tdata[84:77]),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_visible (m_tuser),
        .out_color   (color),
        .out_prio    (prio)
    );

    // Pack the output word
    assign m_tdata = {6'b0, prio, color};

endmodule

// ===== sim/tb_sprite_pixel_texel_fetch_core.sv =====
// Testbench for the sprite pixel texel fetch core: a scoreboard of predicted pixel words.
module tb_sprite_pixel_texel_fetch_core
    import sptf_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int OBJ_POOL = 24;

    typedef struct {
        bit        vis;
        bit [15:0] color;
        bit [1:0]  prio;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;

    // Shadow copies of the block's stores and registers
    logic [7:0]  tile_mem [32768];
    logic [15:0] pal_mem [256];
    logic [15:0] coef_mem [128];
    logic [53:0] geo_mem [NUM_OBJECTS];
    logic [25:0] attr_mem [NUM_OBJECTS];
    logic [2:0]  mode_r;
    logic        linear_r;
    logic [3:0]  mos_w_r;
    logic [3:0]  mos_h_r;

    // Entries written so far
    bit          tile_wr [32768];
    bit          pal_wr [256];
    bit          coef_wr [COEF_NUM];

    // Tile byte and palette entry read by the last prediction, -1 for none
    int          probe_tile;
    int          probe_pal;

    pixel_t pending_pixels [$];
    int     errors;
    int     cycles;
    bit     sender_calm;
    bit     receiver_calm;

    sprite_pixel_texel_fetch_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sprite_pixel_texel_fetch_core test failed");
            $finish;
        end
    end

    // Randomly stall the output side
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= receiver_calm ? 1'b1 : ($urandom_range(99) >= 31);
    end

    // Compare each output word with the oldest prediction
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected word vis=%0b color=%h prio=%0d", $time,
                         m_tuser, m_tdata[15:0], m_tdata[17:16]);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (m_tuser !== want.vis)
                begin
                    $display("%0t: visible expected %0b actual %0b", $time, want.vis, m_tuser);
                    errors++;
                end
                if (m_tdata[15:0] !== want.color)
                begin
                    $display("%0t: color expected %h actual %h", $time, want.color,
                             m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[17:16] !== want.prio)
                begin
                    $display("%0t: priority expected %0d actual %0d", $time, want.prio,
                             m_tdata[17:16]);
                    errors++;
                end
            end
        end
    end

    function automatic int sext9(logic [8:0] v);
        return v[8] ? int'(v) - 512 : int'(v);
    endfunction

    function automatic int coef_at(int entry);
        logic [15:0] c;
        c = coef_mem[entry & 8'h7F];
        return c[15] ? int'(c) - 65536 : int'(c);
    endfunction

    // Resolve one object at one screen pixel
    function automatic pixel_t shade_pixel(int obj, int px, int py);
        pixel_t      res;
        logic [53:0] geo;
        logic [25:0] at;
        logic [4:0]  flex;
        int          ox, oy, cx, cy, xs, ys, lx, ly, rx, ry, base, dx, dy;
        int unsigned tile, addr, ci, step, w, pidx;
        logic [7:0]  byte_v;
        res = '{0, 0, 0};
        probe_tile = -1;
        probe_pal = -1;
        geo = geo_mem[obj];
        at = attr_mem[obj];
        ox = sext9(geo[8:0]);
        oy = sext9(geo[17:9]);
        cx = sext9(geo[26:18]);
        cy = sext9(geo[35:27]);
        xs = int'(geo[44:36]);
        ys = int'(geo[53:45]);
        flex = at[6:2];
        if (at[0])
        begin
            base = (int'(flex) % NUM_AFFINE_GROUPS) * 4;
            dx = px - cx;
            dy = py - cy;
            rx = coef_at(base) * dx + coef_at(base + 1) * dy;
            ry = coef_at(base + 2) * dx + coef_at(base + 3) * dy;
            lx = (xs >>> 1) + (rx >>> 8);
            ly = (ys >>> 1) + (ry >>> 8);
            if (lx < 0 || lx >= xs || ly < 0 || ly >= ys)
                return res;
            if (at[7])
            begin
                lx -= lx % (int'(mos_w_r) + 1);
                ly -= ly % (int'(mos_h_r) + 1);
            end
        end
        else
        begin
            if (at[1])
                return res;
            lx = px - ox;
            ly = py - oy;
            if (lx < 0 || lx >= xs || ly < 0 || ly >= ys)
                return res;
            if (at[7])
            begin
                lx -= lx % (int'(mos_w_r) + 1);
                ly -= ly % (int'(mos_h_r) + 1);
            end
            if (flex[3])
                lx = xs - lx - 1;
            if (flex[4])
                ly = ys - ly - 1;
        end
        if (mode_r >= 3 && int'(at[17:8]) < BITMAP_MIN_TILE)
            return res;
        step = at[18] ? 2 : 1;
        w = xs / 8;
        if (linear_r)
            tile = at[17:8] + ((ly / 8) * w + lx / 8) * step;
        else
            tile = at[17:8] + (ly / 8) * 32 + (lx / 8) * step;
        if (at[18])
        begin
            addr = (tile * 32 + (ly % 8) * 8 + lx % 8) & 16'h7FFF;
            probe_tile = int'(addr);
            ci = tile_mem[addr];
            if (ci == 0)
                return res;
            pidx = ci & 8'hFF;
        end
        else
        begin
            addr = (tile * 32 + (ly % 8) * 4 + (lx % 8) / 2) & 16'h7FFF;
            probe_tile = int'(addr);
            byte_v = tile_mem[addr];
            ci = (lx % 2) ? byte_v[7:4] : byte_v[3:0];
            if (ci == 0)
                return res;
            pidx = (at[22:19] * 16 + ci) & 8'hFF;
        end
        probe_pal = int'(pidx);
        res.color = pal_mem[pidx];
        res.vis = 1'b1;
        res.prio = at[24:23];
        return res;
    endfunction

    // Apply an accepted word to the shadow state and queue its result
    function automatic void absorb_word(logic [2:0] cmd, int idx, logic [53:0] data,
                                        int px, int py);
        pixel_t res;
        res = '{0, 0, 0};
        case (cmd)
            CMD_TILE:
            begin
                tile_mem[idx & 16'h7FFF] = data[7:0];
                tile_wr[idx & 16'h7FFF] = 1'b1;
            end
            CMD_PAL:
            begin
                pal_mem[idx & 8'hFF] = data[15:0];
                pal_wr[idx & 8'hFF] = 1'b1;
            end
            CMD_AFF:
                if (idx < COEF_NUM)
                begin
                    coef_mem[idx] = data[15:0];
                    coef_wr[idx] = 1'b1;
                end
            CMD_GEO:  if (idx < NUM_OBJECTS) geo_mem[idx] = data;
            CMD_ATTR: if (idx < NUM_OBJECTS) attr_mem[idx] = data[25:0];
            CMD_DRAW: if (idx < NUM_OBJECTS) res = shade_pixel(idx, px, py);
            default: ;
        endcase
        pending_pixels.push_back(res);
    endfunction

    // Send one word, sometimes with a random gap ahead of it
    task automatic push_word(logic [2:0] cmd, int idx, logic [53:0] data, int px, int py);
        if (!sender_calm && $urandom_range(99) < 31)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {3'b0, py[7:0], px[7:0], data, idx[14:0]};
        do
            @(posedge clk);
        while (!s_tready);
        absorb_word(cmd, idx, data, px, py);
    endtask

    // Drain all results and let the block fall idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [3:0] val);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:   mode_r = val[2:0];
            CFG_LINEAR: linear_r = val[0];
            CFG_MOS_W:  mos_w_r = val;
            default:    mos_h_r = val;
        endcase
    endtask

    task automatic set_all_regs(logic [2:0] m, logic lin, logic [3:0] mw, logic [3:0] mh);
        set_reg(CFG_MODE, {1'b0, m});
        set_reg(CFG_LINEAR, {3'b0, lin});
        set_reg(CFG_MOS_W, mw);
        set_reg(CFG_MOS_H, mh);
    endtask

    function automatic logic [53:0] geo_word(int x, int y, int cx, int cy, int xs, int ys);
        return {ys[8:0], xs[8:0], cy[8:0], cx[8:0], y[8:0], x[8:0]};
    endfunction

    // Mostly sensible object placement with a few odd sizes
    function automatic logic [53:0] random_geo();
        int xs, ys;
        xs = 8 * $urandom_range(1, 8);
        ys = 8 * $urandom_range(1, 8);
        if ($urandom_range(19) == 0)
            xs = $urandom_range(0, 511);
        if ($urandom_range(19) == 0)
            ys = $urandom_range(0, 511);
        return geo_word($urandom_range(0, 260) - 20, $urandom_range(0, 180) - 20,
                        $urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
                        xs, ys);
    endfunction

    function automatic logic [53:0] random_attr();
        logic [25:0] a;
        a = 26'($urandom);
        a[0] = ($urandom_range(99) < 30);
        a[1] = ($urandom_range(99) < 10);
        a[7] = ($urandom_range(99) < 25);
        return {28'b0, a};
    endfunction

    // Coefficients near identity, some fully random
    function automatic logic [15:0] random_coef(int entry);
        int v;
        if ($urandom_range(99) < 20)
            return 16'($urandom);
        if (entry % 4 == 0 || entry % 4 == 3)
            v = $urandom_range(96, 512) * ($urandom_range(3) == 0 ? -1 : 1);
        else
            v = $urandom_range(0, 160) - 80;
        return v[15:0];
    endfunction

    // Write each still unwritten coefficient, tile or palette entry a draw is about to read, then send the draw
    task automatic draw_at(int obj, int px, int py);
        logic [25:0] at;
        int          base, k;
        if (obj < NUM_OBJECTS)
        begin
            at = attr_mem[obj];
            if (at[0])
            begin
                base = (int'(at[6:2]) % NUM_AFFINE_GROUPS) * 4;
                for (k = base; k < base + 4; k++)
                    if (!coef_wr[k])
                        push_word(CMD_AFF, k, {38'b0, random_coef(k)}, 0, 0);
            end
            void'(shade_pixel(obj, px, py));
            if (probe_tile >= 0 && !tile_wr[probe_tile])
                push_word(CMD_TILE, probe_tile, 54'($urandom), 0, 0);
            void'(shade_pixel(obj, px, py));
            if (probe_pal >= 0 && !pal_wr[probe_pal])
                push_word(CMD_PAL, probe_pal, 54'($urandom), 0, 0);
        end
        push_word(CMD_DRAW, obj, 54'($urandom), px, py);
    endtask

    // Draw a pixel near the object so most draws land inside it
    task automatic draw_near(int obj);
        logic [53:0] geo;
        int px, py, xs, ys;
        geo = geo_mem[obj];
        xs = int'(geo[44:36]) & 127;
        ys = int'(geo[53:45]) & 127;
        if (attr_mem[obj][0])
        begin
            px = sext9(geo[26:18]) - xs + $urandom_range(0, 2 * xs);
            py = sext9(geo[35:27]) - ys + $urandom_range(0, 2 * ys);
        end
        else
        begin
            px = sext9(geo[8:0]) - 2 + $urandom_range(0, xs + 4);
            py = sext9(geo[17:9]) - 2 + $urandom_range(0, ys + 4);
        end
        px = (px < 0) ? 0 : (px > 239) ? 239 : px;
        py = (py < 0) ? 0 : (py > 159) ? 159 : py;
        draw_at(obj, px, py);
    endtask

    // Give every object that draws use a geometry and attribute record
    task automatic test_load_stores();
        int i;
        sender_calm = 1'b1;
        receiver_calm = 1'b1;
        for (i = 0; i < OBJ_POOL; i++)
        begin
            push_word(CMD_GEO, i, random_geo(), 0, 0);
            push_word(CMD_ATTR, i, random_attr(), 0, 0);
        end
        push_word(CMD_GEO, NUM_OBJECTS - 1, random_geo(), 0, 0);
        push_word(CMD_ATTR, NUM_OBJECTS - 1, random_attr(), 0, 0);
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
    endtask

    // Edge cases: flips, disable, bounds, affine, odd commands, extremes
    task automatic test_directed();
        push_word(CMD_GEO, 0, geo_word(0, 0, 0, 0, 8, 8), 0, 0);
        push_word(CMD_ATTR, 0, 54'h0, 0, 0);
        draw_at(0, 0, 0);
        draw_at(0, 7, 7);
        draw_at(0, 8, 0);
        push_word(CMD_ATTR, 0, 54'h18 << 2 | (54'h3 << 23), 0, 0);
        draw_at(0, 1, 2);
        push_word(CMD_ATTR, 0, 54'h2, 0, 0);
        draw_at(0, 3, 3);
        push_word(CMD_GEO, 1, geo_word(-8, -8, 120, 80, 16, 16), 0, 0);
        push_word(CMD_ATTR, 1, {28'b0, 26'h3FFFF81}, 0, 0);
        draw_at(1, 121, 80);
        push_word(CMD_GEO, 2, geo_word(232, 152, 0, 0, 8, 8), 0, 0);
        push_word(CMD_ATTR, 2, {28'b0, 26'h3FFFF00}, 0, 0);
        draw_at(2, 239, 159);
        draw_at(32767, 0, 0);
        push_word(CMD_GEO, 200, {54{1'b1}}, 0, 0);
        push_word(CMD_AFF, 200, {54{1'b1}}, 0, 0);
        push_word(3'd6, 5, {54{1'b1}}, 239, 159);
        push_word(3'd7, 32767, 54'h0, 0, 0);
        push_word(CMD_PAL, 32767, {38'b0, 16'hFFFF}, 0, 0);
        push_word(CMD_TILE, 32767, {46'b0, 8'hFF}, 0, 0);
        settle();
    endtask

    // Random mix of record rewrites, store writes, noise and draws
    task automatic random_batch(int n);
        int i, obj, pick, idx;
        logic [2:0] kind;
        for (i = 0; i < n; i++)
        begin
            obj = ($urandom_range(19) == 0) ? NUM_OBJECTS - 1 : $urandom_range(0, OBJ_POOL - 1);
            pick = $urandom_range(99);
            if (pick < 6)
                push_word(CMD_GEO, obj, random_geo(), 0, 0);
            else if (pick < 12)
                push_word(CMD_ATTR, obj, random_attr(), 0, 0);
            else if (pick < 15)
            begin
                obj = $urandom_range(0, COEF_NUM - 1);
                push_word(CMD_AFF, obj, {38'b0, random_coef(obj)}, 0, 0);
            end
            else if (pick < 19)
                push_word(CMD_TILE, $urandom_range(0, 32767), 54'($urandom), 0, 0);
            else if (pick < 21)
                push_word(CMD_PAL, $urandom_range(0, 32767), 54'($urandom), 0, 0);
            else if (pick < 24)
            begin
                // Noise draws stay on object numbers past the table
                kind = 3'($urandom_range(0, 7));
                idx = $urandom_range(0, 32767);
                if (kind == CMD_DRAW && idx < NUM_OBJECTS)
                    idx += NUM_OBJECTS;
                push_word(kind, idx, 54'({$urandom, $urandom}),
                          $urandom_range(0, 239), $urandom_range(0, 159));
            end
            else
                draw_near(obj);
        end
    endtask

    // Sweep register settings, extremes included
    task automatic test_registers();
        set_all_regs(3'd3, 1'b1, 4'd15, 4'd15);
        random_batch(30);
        set_all_regs(3'd5, 1'b0, 4'd0, 4'd15);
        random_batch(30);
        set_all_regs(3'd2, 1'b1, 4'd15, 4'd0);
        random_batch(30);
        set_all_regs(3'($urandom_range(0, 5)), 1'($urandom), 4'($urandom), 4'($urandom));
        random_batch(30);
        set_all_regs(3'd0, 1'b0, 4'd0, 4'd0);
    endtask

    // Long random run with a calm stretch and a full drain in the middle
    task automatic test_random();
        set_all_regs(3'($urandom_range(0, 2)), 1'($urandom), 4'($urandom), 4'($urandom));
        random_batch(80);
        settle();
        sender_calm = 1'b1;
        receiver_calm = 1'b1;
        random_batch(50);
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        random_batch(70);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        probe_tile = -1;
        probe_pal = -1;
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        mode_r = '0;
        linear_r = 1'b0;
        mos_w_r = '0;
        mos_h_r = '0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_load_stores();
        test_directed();
        test_registers();
        test_random();
        settle();
        if (errors == 0)
            $display("sprite_pixel_texel_fetch_core test passed");
        else
            $display("sprite_pixel_texel_fetch_core test failed");
        $finish;
    end

endmodule
